[rtl/core/adm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types and constants for the anagram dictionary matcher: result
// codes, field widths and character-class limits.
// ----------------------------------------------------------------------------
package adm_pkg;

    // letters of the alphabet held in one signature
    localparam int LETTERS = 26;
    localparam int LETTER_W = 5;

    // fixed field and counter widths
    localparam int CHAR_W = 8;
    localparam int STATUS_W = 3;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 6;
    localparam int LEN_W = 7;
    localparam int MIN_WORD_LEN = 2;

    // saturation limits of the word counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // character class bounds
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // word kind carried on the input side
    localparam logic ACTION_DICT = 1'b0;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_INVALID = 3'd2,
        ST_BADLEN  = 3'd3,
        ST_LOADED  = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    // one letter signature: a 6-bit count per letter
    typedef logic [LETTERS-1:0][COUNT_W-1:0] signature_t;

endpackage

[rtl/core/anagram_dictionary_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_dictionary_matcher
// Stores dictionary words as letter signatures and reports, for each query
// word, the index of every stored entry that is an anagram of it.
// ----------------------------------------------------------------------------
// Words arrive one character per transaction, tuser selecting dictionary (0)
// or query (1) and tlast marking the final character; the kind of the word is
// taken from its final character. The end of a dictionary word gives one
// result (loaded, dictionary full, bad length or invalid char), and so does
// the end of a query word rejected for an invalid char or a bad length. For
// any other query word the stored signatures are scanned: they sit in one
// memory with a single registered read port, and one row comparator checks
// one entry at a time (read, then compare). A query gives one match result
// per anagram found, or a single no-match result; tlast marks the final
// result of each word. An output stall holds the handling of a word end. No
// input is taken while a word end is being handled.
module anagram_dictionary_matcher
    import adm_pkg::*;
#(
    parameter int DICT_DEPTH = 64,
    parameter int MAX_WORD_LEN = 45
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                s_tuser,   // [0] action
    input  logic                s_tlast,   // last_char

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [5:0] entry_index, [7:6] zero
    output logic [STATUS_W-1:0] m_tuser,   // [2:0] status
    output logic                m_tlast    // last_result
);

    localparam int ADDR_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CNT_W = $clog2(DICT_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECIDE   = 5'b00010,
        S_SCAN_RD  = 5'b00100,
        S_SCAN_CMP = 5'b01000,
        S_FINISH   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    signature_t word_cnt_reg, word_cnt_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic word_inv_reg, word_inv_next;
    logic action_reg, action_next;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [ADDR_W-1:0] scan_idx_reg, scan_idx_next;
    logic pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;

    // signature memory and its registered read
    signature_t mem [DICT_DEPTH];
    signature_t rd_row_reg;
    logic mem_we;

    logic m_tvalid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    status_t m_status_reg;
    logic m_tlast_reg;

    logic in_accept;
    logic out_free;
    logic [CHAR_W-1:0] ch_lower;
    logic is_letter;
    logic [LETTER_W-1:0] letter;
    logic bad_len;
    logic dict_full;
    logic row_equal;
    logic scan_at_end;
    logic word_clear;

    logic emit;
    status_t emit_status;
    logic [INDEX_W-1:0] emit_index;
    logic emit_last;

    assign s_tready = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // character classification with case folding
    always_comb begin
        if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_Z) begin
            ch_lower = s_tdata + CASE_OFFSET;
        end else begin
            ch_lower = s_tdata;
        end
        is_letter = (ch_lower >= CHAR_LOWER_A) && (ch_lower <= CHAR_LOWER_Z);
        letter = LETTER_W'(ch_lower - CHAR_LOWER_A);
    end

    // word checks and the shared row comparator
    assign bad_len = (word_len_reg < LEN_W'(MIN_WORD_LEN)) ||
                     (word_len_reg > LEN_W'(MAX_WORD_LEN));
    assign dict_full = (entry_count_reg >= CNT_W'(DICT_DEPTH));
    assign row_equal = (rd_row_reg == word_cnt_reg);
    assign scan_at_end = (CNT_W'(CNT_W'(scan_idx_reg) + CNT_W'(1)) == entry_count_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        entry_count_next = entry_count_reg;
        scan_idx_next = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next = pend_idx_reg;
        action_next = action_reg;
        mem_we = 1'b0;
        word_clear = 1'b0;
        emit = 1'b0;
        emit_status = ST_NOMATCH;
        emit_index = '0;
        emit_last = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (in_accept && s_tlast) begin
                    action_next = s_tuser;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (action_reg == ACTION_DICT) begin
                    if (out_free) begin
                        emit = 1'b1;
                        word_clear = 1'b1;
                        state_next = S_IDLE;
                        if (bad_len) begin
                            emit_status = ST_BADLEN;
                        end else if (word_inv_reg) begin
                            emit_status = ST_INVALID;
                        end else if (dict_full) begin
                            emit_status = ST_FULL;
                        end else begin
                            emit_status = ST_LOADED;
                            emit_index = INDEX_W'(entry_count_reg);
                            mem_we = 1'b1;
                            entry_count_next = entry_count_reg + CNT_W'(1);
                        end
                    end
                end else if (word_inv_reg || bad_len) begin
                    if (out_free) begin
                        emit = 1'b1;
                        emit_status = word_inv_reg ? ST_INVALID : ST_BADLEN;
                        word_clear = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    pend_valid_next = 1'b0;
                    scan_idx_next = '0;
                    state_next = (entry_count_reg == '0) ? S_FINISH : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // a new match releases the one held before it
                if (!(row_equal && pend_valid_reg) || out_free) begin
                    if (row_equal) begin
                        if (pend_valid_reg) begin
                            emit = 1'b1;
                            emit_status = ST_MATCH;
                            emit_index = INDEX_W'(pend_idx_reg);
                            emit_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next = scan_idx_reg;
                    end
                    if (scan_at_end) begin
                        state_next = S_FINISH;
                    end else begin
                        scan_idx_next = scan_idx_reg + ADDR_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_status = pend_valid_reg ? ST_MATCH : ST_NOMATCH;
                    emit_index = pend_valid_reg ? INDEX_W'(pend_idx_reg) : '0;
                    word_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // word accumulation, cleared after every word end
    always_comb begin
        word_cnt_next = word_cnt_reg;
        word_len_next = word_len_reg;
        word_inv_next = word_inv_reg;
        if (word_clear) begin
            word_cnt_next = '0;
            word_len_next = '0;
            word_inv_next = 1'b0;
        end else if (in_accept) begin
            if (word_len_reg != LEN_MAX) begin
                word_len_next = word_len_reg + LEN_W'(1);
            end
            if (is_letter) begin
                if (word_cnt_reg[letter] != COUNT_MAX) begin
                    word_cnt_next[letter] = word_cnt_reg[letter] + COUNT_W'(1);
                end
            end else begin
                word_inv_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            word_cnt_reg <= '0;
            word_len_reg <= '0;
            word_inv_reg <= 1'b0;
            entry_count_reg <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            word_cnt_reg <= word_cnt_next;
            word_len_reg <= word_len_next;
            word_inv_reg <= word_inv_next;
            entry_count_reg <= entry_count_next;
            pend_valid_reg <= pend_valid_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        if (emit) begin
            m_status_reg <= emit_status;
            m_index_reg <= emit_index;
            m_tlast_reg <= emit_last;
        end
    end

    // signature memory: row write at load, registered row read for the scan
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ADDR_W'(entry_count_reg)] <= word_cnt_reg;
        end
        rd_row_reg <= mem[scan_idx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {2'b00, m_index_reg};
    assign m_tuser = m_status_reg;
    assign m_tlast = m_tlast_reg;

    // entry count never passes the dictionary depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_W'(DICT_DEPTH))
        else $error("entry count beyond dictionary depth");

    // a row is only written while the dictionary has room
    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !dict_full)
        else $error("signature written into a full dictionary");

    // the scan only runs for a valid word of legal length
    a_scan_word_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN_CMP) |-> (!word_inv_reg && !bad_len))
        else $error("scan running for a rejected word");

    // a match names a stored entry
    a_match_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_status == ST_MATCH) |->
            (CNT_W'(emit_index) < entry_count_reg))
        else $error("match index beyond stored entries");

    // a scan result waits while the output is stalled
    a_scan_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FINISH) && m_tvalid_reg && !m_tready) |=>
            (state_reg == S_FINISH))
        else $error("scan finish left under output stall");

endmodule
